/* design/vertex_transform_perspective_divide_unit_assert.svh */
// Assertion macros shared by the vertex transform and divide block.
// Each macro expands to one clocked concurrent assertion on clk and arst_n.
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_UNIT_ASSERT_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define VTPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define VTPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/vtpd_pkg.sv */
// Package for the vertex transform and perspective divide block.
// Holds widths and constants used by all modules, and the divider control struct.
`default_nettype none
package vtpd_pkg;
	localparam int COORD_W    = 32;
	localparam int ACC_W      = 66;
	localparam int DIV_STEPS  = 34;
	localparam int NUM_REGS   = 8;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;
	localparam int LANES      = 3;

	localparam logic [COORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

	typedef struct packed {
		logic             vld;
		logic             wz;
		logic [LANES-1:0] neg;
	} div_ctl_t;
endpackage
`default_nettype wire

/* design/vtpd_if.sv */
// Stream interfaces for vertex items in and screen items out.
// Depends on vtpd_pkg for the coordinate width.
`default_nettype none
interface vtpd_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [vtpd_pkg::COORD_W-1:0] pos_x;
	logic signed [vtpd_pkg::COORD_W-1:0] pos_y;
	logic signed [vtpd_pkg::COORD_W-1:0] pos_z;
	modport source(output valid, output pos_x, output pos_y, output pos_z, input ready);
	modport sink(input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface vtpd_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [vtpd_pkg::COORD_W-1:0] screen_x;
	logic signed [vtpd_pkg::COORD_W-1:0] screen_y;
	logic signed [vtpd_pkg::COORD_W-1:0] screen_z;
	logic                                 w_zero;
	modport source(output valid, output screen_x, output screen_y, output screen_z,
		output w_zero, input ready);
	modport sink(input valid, input screen_x, input screen_y, input screen_z,
		input w_zero, output ready);
endinterface
`default_nettype wire

/* design/vtpd_mac.sv */
// Three-stage matrix multiply: products, pair sums, final accumulators.
// Depends on vtpd_pkg.
`default_nettype none
module vtpd_mac #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  en,
	input  wire logic                                  in_vld,
	input  wire logic signed [vtpd_pkg::COORD_W-1:0]   vx,
	input  wire logic signed [vtpd_pkg::COORD_W-1:0]   vy,
	input  wire logic signed [vtpd_pkg::COORD_W-1:0]   vz,
	input  wire logic signed [vtpd_pkg::COORD_W-1:0]   mat [4][4],
	output logic                                       out_vld,
	output logic signed [vtpd_pkg::ACC_W-1:0]          acc [4]
);
	localparam int PW = 2 * vtpd_pkg::COORD_W;

	logic signed [PW-1:0]                   prod_s1 [4][4];
	logic signed [PW:0]                     psum_s2 [4][2];
	logic signed [vtpd_pkg::ACC_W-1:0]      acc_s3  [4];
	logic                                   vld_s1, vld_s2, vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				prod_s1[0][j] <= vx * mat[0][j];
				prod_s1[1][j] <= vy * mat[1][j];
				prod_s1[2][j] <= vz * mat[2][j];
				prod_s1[3][j] <= PW'(mat[3][j]) <<< FRAC_BITS;
				psum_s2[j][0] <= (PW+1)'(prod_s1[0][j]) + (PW+1)'(prod_s1[1][j]);
				psum_s2[j][1] <= (PW+1)'(prod_s1[2][j]) + (PW+1)'(prod_s1[3][j]);
				acc_s3[j] <= vtpd_pkg::ACC_W'(psum_s2[j][0])
					+ vtpd_pkg::ACC_W'(psum_s2[j][1]);
			end
		end
	end

	assign out_vld = vld_s3;
	assign acc     = acc_s3;
endmodule
`default_nettype wire

/* design/vtpd_divider.sv */
// Pipelined restoring divider: one sign stage, one quotient bit per stage
// for three numerators over a shared divisor, then saturation logic.
// Depends on vtpd_pkg.
`default_nettype none
module vtpd_divider #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  en,
	input  wire logic                                  in_vld,
	input  wire logic signed [vtpd_pkg::ACC_W-1:0]     acc [4],
	output vtpd_pkg::div_ctl_t                         res_ctl,
	output logic [vtpd_pkg::COORD_W-1:0]               res [vtpd_pkg::LANES]
);
	localparam int AW = vtpd_pkg::ACC_W;
	localparam int ST = vtpd_pkg::DIV_STEPS;
	localparam int NL = vtpd_pkg::LANES;
	localparam int CW = (AW + ST > AW + FRAC_BITS) ? AW + ST : AW + FRAC_BITS;
	localparam int QW = ST - 1;

	logic [CW-1:0]         rem_s [ST+1][NL];
	logic [ST-1:0]         quo_s [ST+1][NL];
	logic [AW-1:0]         den_s [ST+1];
	vtpd_pkg::div_ctl_t    ctl_s [ST+1];
	logic [AW-1:0]         mag   [4];

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			mag[j] = acc[j][AW-1] ? AW'(-acc[j]) : AW'(acc[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0].vld <= in_vld;
			ctl_s[0].wz  <= (acc[3] == '0);
			for (int j = 0; j < NL; j++) begin
				ctl_s[0].neg[j] <= acc[j][AW-1] ^ acc[3][AW-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= mag[3];
			for (int j = 0; j < NL; j++) begin
				rem_s[0][j] <= CW'(mag[j]) << FRAC_BITS;
				quo_s[0][j] <= '0;
			end
		end
	end

	for (genvar k = 1; k <= ST; k++) begin : g_step
		logic [CW-1:0] dsh;
		logic [NL-1:0] ge;

		always_comb begin
			dsh = CW'(den_s[k-1]) << (ST - k);
			for (int j = 0; j < NL; j++) begin
				ge[j] = rem_s[k-1][j] >= dsh;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else if (en) begin
				ctl_s[k] <= ctl_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= den_s[k-1];
				for (int j = 0; j < NL; j++) begin
					rem_s[k][j] <= ge[j] ? rem_s[k-1][j] - dsh : rem_s[k-1][j];
					quo_s[k][j] <= {quo_s[k-1][j][ST-2:0], ge[j]};
				end
			end
		end
	end

	// The top quotient bit marks a quotient of 2^33 or more.
	always_comb begin
		logic          ovf;
		logic [QW-1:0] q;
		for (int j = 0; j < NL; j++) begin
			ovf = quo_s[ST][j][ST-1];
			q   = quo_s[ST][j][QW-1:0];
			if (ctl_s[ST].wz) begin
				res[j] = '0;
			end else if (ctl_s[ST].neg[j]) begin
				res[j] = (ovf || q > QW'(vtpd_pkg::SAT_NEG)) ? vtpd_pkg::SAT_NEG
					: vtpd_pkg::COORD_W'(0) - q[vtpd_pkg::COORD_W-1:0];
			end else begin
				res[j] = (ovf || q > QW'(vtpd_pkg::SAT_POS)) ? vtpd_pkg::SAT_POS
					: q[vtpd_pkg::COORD_W-1:0];
			end
		end
	end

	assign res_ctl = ctl_s[ST];
endmodule
`default_nettype wire

/* design/vertex_transform_perspective_divide_unit.sv */
// Vertex transform by a 4x4 matrix followed by the perspective divide.
// Depends on vtpd_pkg, vtpd_if, vtpd_mac, vtpd_divider and the assert header.
//
// Usage: vertex items (pos_x, pos_y, pos_z, signed fixed point) enter on the
// vtx channel and screen items (screen_x, screen_y, screen_z, w_zero) leave
// on the scr channel, both valid/ready streams. The matrix is written through
// cfg_we, cfg_idx and cfg_data, one 64-bit register per write; the user must
// write it only while idle, which the block does not enforce. Indexes above
// seven are ignored. An accepted item passes three multiply and sum stages, one
// sign stage, 34 divider stages with one quotient bit each, and the output
// register. Throughput is one item per cycle while the pipeline is not held.
// All stages move together; when the output register holds an item that the
// receiver has not taken, the whole pipeline holds and vtx.ready is low.
// Reset clears every valid bit and the matrix registers to zero.
`default_nettype none
`include "vertex_transform_perspective_divide_unit_assert.svh"
module vertex_transform_perspective_divide_unit #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	vtpd_in_if.sink                                   vtx,
	vtpd_out_if.source                                scr,
	input  wire logic                                 cfg_we,
	input  wire logic [vtpd_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  wire logic [vtpd_pkg::CFG_DATA_W-1:0]      cfg_data
);
	localparam int CWD = vtpd_pkg::COORD_W;

	logic [vtpd_pkg::NUM_REGS-1:0][vtpd_pkg::CFG_DATA_W-1:0] mat_q;
	logic signed [CWD-1:0]                  mat [4][4];
	logic                                   adv;
	logic                                   mac_vld;
	logic signed [vtpd_pkg::ACC_W-1:0]      acc [4];
	vtpd_pkg::div_ctl_t                     res_ctl;
	logic [CWD-1:0]                         res [vtpd_pkg::LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= '0;
		end else if (cfg_we && cfg_idx < vtpd_pkg::CFG_IDX_W'(vtpd_pkg::NUM_REGS)) begin
			mat_q[cfg_idx[$clog2(vtpd_pkg::NUM_REGS)-1:0]] <= cfg_data;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mat[i][0] = mat_q[2*i][63:32];
			mat[i][1] = mat_q[2*i][31:0];
			mat[i][2] = mat_q[2*i+1][63:32];
			mat[i][3] = mat_q[2*i+1][31:0];
		end
	end

	assign adv       = !scr.valid || scr.ready;
	assign vtx.ready = adv;

	vtpd_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (vtx.valid),
		.vx      (vtx.pos_x),
		.vy      (vtx.pos_y),
		.vz      (vtx.pos_z),
		.mat     (mat),
		.out_vld (mac_vld),
		.acc     (acc)
	);

	vtpd_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (mac_vld),
		.acc     (acc),
		.res_ctl (res_ctl),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr.valid <= 1'b0;
		end else if (adv) begin
			scr.valid <= res_ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			scr.screen_x <= res[0];
			scr.screen_y <= res[1];
			scr.screen_z <= res[2];
			scr.w_zero   <= res_ctl.wz;
		end
	end

	`VTPD_ASSERT_NOW(a_wzero_clears, scr.valid && scr.w_zero,
		scr.screen_x == '0 && scr.screen_y == '0 && scr.screen_z == '0,
		"w_zero item carries nonzero coordinates")
	`VTPD_ASSERT_NOW(a_stall_only_when_full, !vtx.ready, scr.valid,
		"input stalled while output register is empty")
	`VTPD_ASSERT_NEXT(a_bad_index_ignored,
		cfg_we && cfg_idx >= vtpd_pkg::CFG_IDX_W'(vtpd_pkg::NUM_REGS),
		$stable(mat_q), "write to unused index changed the matrix")
endmodule
`default_nettype wire
